[hdl/lqrm_pkg.sv]
// ----------------------------------------------------------------------------
// lqrm_pkg
// Shared types, codes and helpers for the link quality retry monitor.
// ----------------------------------------------------------------------------
package lqrm_pkg;

    localparam int unsigned CNT_W  = 8;
    localparam int unsigned LVL_W  = 3;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned ACT_W  = 3;
    localparam int unsigned OC_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUALITY    = 3'd0,
        KIND_LINK_DOWN  = 3'd1,
        KIND_LINK_UP    = 3'd2,
        KIND_LINK_RETRY = 3'd3,
        KIND_TIMEOUT    = 3'd4,
        KIND_REQ_RETRY  = 3'd5,
        KIND_OUTCOME    = 3'd6,
        KIND_NO_NETWORK = 3'd7
    } t_kind;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE      = 3'd0,
        ACT_SHOW_REQ  = 3'd1,
        ACT_SHOW_LINK = 3'd2,
        ACT_HIDE      = 3'd3,
        ACT_POOR      = 3'd4,
        ACT_NOCONN    = 3'd5,
        ACT_RESEND    = 3'd6
    } t_action;

    typedef enum logic [OC_W-1:0] {
        OC_DONE         = 2'd0,
        OC_DISCONNECTED = 2'd1,
        OC_TIMEOUT      = 2'd2,
        OC_OTHER        = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAD_TRIGGER   = 3'd0,
        CFG_GOOD_RECOVER  = 3'd1,
        CFG_BAD_LEVEL     = 3'd2,
        CFG_GOOD_LEVEL    = 3'd3,
        CFG_COOLDOWN      = 3'd4,
        CFG_LINK_RETRY    = 3'd5,
        CFG_DISCONNECT    = 3'd6,
        CFG_REQ_RETRY     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_kind           kind;
        logic [LVL_W-1:0] quality;
        t_outcome        outcome_class;
    } t_in_item;

    typedef struct packed {
        t_action action;
        logic    forward_result;
        logic    alert_showing;
        logic    link_triggered;
    } t_out_item;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

[hdl/lqrm_in_if.sv]
// ----------------------------------------------------------------------------
// lqrm_in_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface lqrm_in_if;
    logic                         valid;
    logic                         ready;
    logic [lqrm_pkg::KIND_W-1:0]  kind;
    logic [lqrm_pkg::LVL_W-1:0]   quality;
    logic [lqrm_pkg::OC_W-1:0]    outcome_class;

    modport source (output valid, output kind, output quality, output outcome_class,
                    input ready);
    modport sink   (input valid, input kind, input quality, input outcome_class,
                    output ready);
endinterface

[hdl/lqrm_out_if.sv]
// ----------------------------------------------------------------------------
// lqrm_out_if
// Result channel: valid/ready handshake with the action fields.
// ----------------------------------------------------------------------------
interface lqrm_out_if;
    logic                        valid;
    logic                        ready;
    logic [lqrm_pkg::ACT_W-1:0]  action;
    logic                        forward_result;
    logic                        alert_showing;
    logic                        link_triggered;

    modport source (output valid, output action, output forward_result,
                    output alert_showing, output link_triggered, input ready);
    modport sink   (input valid, input action, input forward_result,
                    input alert_showing, input link_triggered, output ready);
endinterface

[hdl/link_quality_retry_monitor.sv]
// ----------------------------------------------------------------------------
// link_quality_retry_monitor
// Weak-link monitor: debounced quality tracking, retry and disconnect counts,
// one action code per event.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries events (kind, quality, outcome_class); o_out carries one
//   result per event (action, forward_result, alert_showing, link_triggered).
//   Both channels use valid/ready; an item moves when both are high.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
//   no event is in flight; the write lands at the next clock edge.
// Timing: an accepted event goes into an input register, is evaluated
//   against the state registers once the output register is free or being
//   taken, and its result is then registered in the output register.
// Throughput: one event per cycle while o_out.ready is high; state is updated
//   in the evaluate cycle, so the following event already sees it.
// Reset: i_rst_n low (synchronous) empties both stages, clears all counters
//   and flags, and loads the default configuration.
// Stall: while o_out.ready is low the output register holds, the input
//   register fills, and then i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module link_quality_retry_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lqrm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lqrm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    lqrm_in_if.sink                             i_in,
    lqrm_out_if.source                          o_out
);

    localparam int unsigned CW = lqrm_pkg::CNT_W;
    localparam int unsigned LW = lqrm_pkg::LVL_W;

    // configuration
    logic [CW-1:0] r_bad_trig, r_good_rec, r_cool_cfg, r_link_lim, r_disc_lim, r_req_lim;
    logic [LW-1:0] r_bad_lvl, r_good_lvl;

    // state
    logic          r_showing, n_showing;
    logic          r_link,    n_link;
    logic [CW-1:0] r_bad_run,  n_bad_run;
    logic [CW-1:0] r_good_run, n_good_run;
    logic [CW-1:0] r_link_retries, n_link_retries;
    logic [CW-1:0] r_cooldown, n_cooldown;
    logic [CW-1:0] r_down_run, n_down_run;
    logic [CW-1:0] r_req_retries, n_req_retries;

    // pipeline
    logic                   r_in_valid;
    lqrm_pkg::t_in_item     r_in;
    logic                   r_out_valid;
    lqrm_pkg::t_out_item    r_out, n_out;
    logic                   eval;

    logic [CW-1:0] bad_inc, good_inc, down_inc, req_inc;
    logic          q_bad, q_good;

    assign eval       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || eval;

    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_out.action;
    assign o_out.forward_result = r_out.forward_result;
    assign o_out.alert_showing  = r_out.alert_showing;
    assign o_out.link_triggered = r_out.link_triggered;

    assign bad_inc  = lqrm_pkg::sat_inc(r_bad_run);
    assign good_inc = lqrm_pkg::sat_inc(r_good_run);
    assign down_inc = lqrm_pkg::sat_inc(r_down_run);
    assign req_inc  = lqrm_pkg::sat_inc(r_req_retries);
    assign q_bad    = r_in.quality >= r_bad_lvl;
    assign q_good   = (r_in.quality != '0) && (r_in.quality <= r_good_lvl);

    always_comb begin
        n_showing      = r_showing;
        n_link         = r_link;
        n_bad_run      = r_bad_run;
        n_good_run     = r_good_run;
        n_link_retries = r_link_retries;
        n_cooldown     = r_cooldown;
        n_down_run     = r_down_run;
        n_req_retries  = r_req_retries;
        n_out.action         = lqrm_pkg::ACT_NONE;
        n_out.forward_result = 1'b0;

        unique case (r_in.kind)
            lqrm_pkg::KIND_QUALITY: begin
                if (q_bad) begin
                    n_good_run = '0;
                    n_bad_run  = bad_inc;
                    if (r_cooldown != '0) begin
                        n_cooldown = r_cooldown - CW'(1);
                    end else if (bad_inc >= r_bad_trig && !r_showing) begin
                        if (r_link_retries >= r_link_lim) begin
                            n_showing      = 1'b0;
                            n_link         = 1'b0;
                            n_bad_run      = '0;
                            n_link_retries = '0;
                            n_down_run     = '0;
                            n_out.action   = lqrm_pkg::ACT_NOCONN;
                        end else begin
                            n_showing    = 1'b1;
                            n_link       = 1'b1;
                            n_out.action = lqrm_pkg::ACT_SHOW_LINK;
                        end
                    end
                end else if (q_good) begin
                    n_bad_run  = '0;
                    n_cooldown = '0;
                    n_good_run = good_inc;
                    if (good_inc >= r_good_rec && r_showing && r_link) begin
                        n_showing      = 1'b0;
                        n_link         = 1'b0;
                        n_good_run     = '0;
                        n_link_retries = '0;
                        n_out.action   = lqrm_pkg::ACT_HIDE;
                    end
                end else begin
                    n_bad_run  = '0;
                    n_good_run = '0;
                end
            end
            lqrm_pkg::KIND_LINK_DOWN: begin
                n_down_run = down_inc;
                if (down_inc >= r_disc_lim) begin
                    n_showing      = 1'b0;
                    n_link         = 1'b0;
                    n_bad_run      = '0;
                    n_good_run     = '0;
                    n_link_retries = '0;
                    n_cooldown     = '0;
                    n_down_run     = '0;
                    n_out.action   = lqrm_pkg::ACT_NOCONN;
                end
            end
            lqrm_pkg::KIND_LINK_UP: begin
                n_down_run = '0;
                n_bad_run  = '0;
                n_good_run = '0;
                n_cooldown = '0;
                if (r_showing && r_link) begin
                    n_showing      = 1'b0;
                    n_link         = 1'b0;
                    n_link_retries = '0;
                    n_out.action   = lqrm_pkg::ACT_HIDE;
                end
            end
            lqrm_pkg::KIND_LINK_RETRY: begin
                if (r_showing && r_link) begin
                    n_link_retries = lqrm_pkg::sat_inc(r_link_retries);
                    n_showing      = 1'b0;
                    n_cooldown     = r_cool_cfg;
                    n_out.action   = lqrm_pkg::ACT_HIDE;
                end
            end
            lqrm_pkg::KIND_TIMEOUT: begin
                if (!r_showing) begin
                    n_req_retries = '0;
                    n_showing     = 1'b1;
                    n_link        = 1'b0;
                    n_out.action  = lqrm_pkg::ACT_SHOW_REQ;
                end
            end
            lqrm_pkg::KIND_REQ_RETRY: begin
                if (r_showing) begin
                    n_out.action = lqrm_pkg::ACT_RESEND;
                end
            end
            lqrm_pkg::KIND_OUTCOME: begin
                case (r_in.outcome_class)
                    lqrm_pkg::OC_DISCONNECTED: begin
                        n_showing    = 1'b0;
                        n_link       = 1'b0;
                        n_bad_run    = '0;
                        n_good_run   = '0;
                        n_out.action = lqrm_pkg::ACT_POOR;
                    end
                    lqrm_pkg::OC_TIMEOUT: begin
                        n_req_retries = req_inc;
                        if (req_inc >= r_req_lim) begin
                            n_showing    = 1'b0;
                            n_link       = 1'b0;
                            n_bad_run    = '0;
                            n_good_run   = '0;
                            n_out.action = lqrm_pkg::ACT_POOR;
                        end else begin
                            n_showing    = 1'b1;
                            n_out.action = lqrm_pkg::ACT_SHOW_REQ;
                        end
                    end
                    default: begin
                        n_showing            = 1'b0;
                        n_link               = 1'b0;
                        n_bad_run            = '0;
                        n_good_run           = '0;
                        n_out.action         = lqrm_pkg::ACT_HIDE;
                        n_out.forward_result = 1'b1;
                    end
                endcase
            end
            lqrm_pkg::KIND_NO_NETWORK: begin
                n_showing    = 1'b0;
                n_link       = 1'b0;
                n_bad_run    = '0;
                n_good_run   = '0;
                n_out.action = lqrm_pkg::ACT_NOCONN;
            end
        endcase

        n_out.alert_showing  = n_showing;
        n_out.link_triggered = n_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_trig <= CW'(2);
            r_good_rec <= CW'(3);
            r_bad_lvl  <= LW'(4);
            r_good_lvl <= LW'(2);
            r_cool_cfg <= CW'(8);
            r_link_lim <= CW'(2);
            r_disc_lim <= CW'(1);
            r_req_lim  <= CW'(2);
        end else if (i_cfg_we) begin
            unique case (lqrm_pkg::t_cfg_idx'(i_cfg_idx))
                lqrm_pkg::CFG_BAD_TRIGGER:  r_bad_trig <= i_cfg_wdata;
                lqrm_pkg::CFG_GOOD_RECOVER: r_good_rec <= i_cfg_wdata;
                lqrm_pkg::CFG_BAD_LEVEL:    r_bad_lvl  <= i_cfg_wdata[LW-1:0];
                lqrm_pkg::CFG_GOOD_LEVEL:   r_good_lvl <= i_cfg_wdata[LW-1:0];
                lqrm_pkg::CFG_COOLDOWN:     r_cool_cfg <= i_cfg_wdata;
                lqrm_pkg::CFG_LINK_RETRY:   r_link_lim <= i_cfg_wdata;
                lqrm_pkg::CFG_DISCONNECT:   r_disc_lim <= i_cfg_wdata;
                lqrm_pkg::CFG_REQ_RETRY:    r_req_lim  <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_showing      <= 1'b0;
            r_link         <= 1'b0;
            r_bad_run      <= '0;
            r_good_run     <= '0;
            r_link_retries <= '0;
            r_cooldown     <= '0;
            r_down_run     <= '0;
            r_req_retries  <= '0;
        end else if (eval) begin
            r_showing      <= n_showing;
            r_link         <= n_link;
            r_bad_run      <= n_bad_run;
            r_good_run     <= n_good_run;
            r_link_retries <= n_link_retries;
            r_cooldown     <= n_cooldown;
            r_down_run     <= n_down_run;
            r_req_retries  <= n_req_retries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (eval) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.kind          <= lqrm_pkg::t_kind'(i_in.kind);
            r_in.quality       <= i_in.quality;
            r_in.outcome_class <= lqrm_pkg::t_outcome'(i_in.outcome_class);
        end
        if (eval) begin
            r_out <= n_out;
        end
    end

endmodule
